// ===== src/b64d_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Base64 decoder: result entry type, the pad character and
// the alphabet lookup. No dependencies.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam int         QUEUE_DEPTH = 4;
  localparam int         GROUP_BYTES = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       bad_symbol;
    logic       end_of_output;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch, input logic url);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if ((url && ch == 8'h2D) || (!url && ch == 8'h2B)) begin
      s.value = 6'd62;
    end else if ((url && ch == 8'h5F) || (!url && ch == 8'h2F)) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== src/base64_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the streaming Base64 decoder with its result queue.
// Depends on b64d_pkg.
//
// Characters arrive on the in_ channel, one per transfer, with
// in_final_symbol on the last character of a message. Decoded bytes leave
// on the out_ channel, one per transfer; out_end_of_output marks the last
// result of a message and out_bad_symbol marks the single error result
// that ends a message holding an invalid character.
// The cfg_ channel writes the alphabet select; it is always ready. The user
// must write it only while the decoder is idle; the block does not enforce this.
// Each accepted character is decoded combinationally. The character that
// completes a group of four, or ends a message, places one to three
// results into a four-entry result queue; when the queue was empty, the first
// result is visible on the out_ channel in the cycle after the input transfer.
// A character that does not complete a group is accepted in every cycle.
// A completing character is accepted when its results fit in the queue
// beside those still waiting, so a continuous stream sustains one
// character per cycle while the receiver takes one result per cycle.
// When the receiver stalls, results wait in the queue and input stops
// only once a completing character finds the queue too full.
// Reset empties the queue, clears the group state and selects the
// standard alphabet.
module base64_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_url_alphabet,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_final_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_bad_symbol,
  output logic       out_end_of_output
);

  localparam int CntW = $clog2(b64d_pkg::QUEUE_DEPTH + 1);

  logic                url_r;
  logic [17:0]         held_r, held_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic                third_pad_r, third_pad_nxt;
  logic                invalid_r, invalid_nxt;
  logic                discard_r, discard_nxt;
  b64d_pkg::result_t   queue_r [b64d_pkg::QUEUE_DEPTH];
  b64d_pkg::result_t   queue_nxt [b64d_pkg::QUEUE_DEPTH];
  logic [CntW-1:0]     cnt_r, cnt_nxt;

  b64d_pkg::sextet_t   sx;
  b64d_pkg::result_t   ent [b64d_pkg::GROUP_BYTES];
  logic                is_pad;
  logic                bad_char;
  logic [5:0]          sx_val;
  logic                completes;
  logic                accept;
  logic                pop;
  logic [23:0]         word;
  logic                third_pad;
  logic                fourth_pad;
  logic                grp_bad;
  logic [1:0]          n_res;
  logic [1:0]          push_n;
  logic [CntW-1:0]     base;
  logic [CntW-1:0]     off;

  assign cfg_ready = 1'b1;

  assign is_pad    = (in_symbol == b64d_pkg::PAD_CHAR);
  assign sx        = b64d_pkg::sextet_of(in_symbol, url_r);
  assign bad_char  = !is_pad && !sx.valid;
  assign sx_val    = (is_pad || !sx.valid) ? 6'd0 : sx.value;
  assign completes = !discard_r && (in_final_symbol || pos_r == 2'd3);
  assign in_ready  = !completes ||
                     ((cnt_r + CntW'(n_res)) <= CntW'(b64d_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;

  assign out_data_byte     = queue_r[0].data_byte;
  assign out_bad_symbol    = queue_r[0].bad_symbol;
  assign out_end_of_output = queue_r[0].end_of_output;

  always_comb begin
    word       = '0;
    third_pad  = 1'b1;
    fourth_pad = 1'b1;
    case (pos_r)
      2'd0: word = {sx_val, 18'd0};
      2'd1: word = {held_r[5:0], sx_val, 12'd0};
      2'd2: begin
        word      = {held_r[11:0], sx_val, 6'd0};
        third_pad = is_pad;
      end
      2'd3: begin
        word       = {held_r, sx_val};
        third_pad  = third_pad_r;
        fourth_pad = is_pad;
      end
      default: word = '0;
    endcase
    grp_bad = invalid_r || bad_char;
    n_res   = 2'd1 + 2'(!third_pad) + 2'(!fourth_pad);
    if (grp_bad) begin
      n_res = 2'd1;
    end
    ent[0] = '{data_byte: word[23:16], bad_symbol: 1'b0, end_of_output: 1'b0};
    ent[1] = '{data_byte: third_pad ? word[7:0] : word[15:8], bad_symbol: 1'b0,
               end_of_output: 1'b0};
    ent[2] = '{data_byte: word[7:0], bad_symbol: 1'b0, end_of_output: 1'b0};
    if (grp_bad) begin
      ent[0] = '{data_byte: 8'd0, bad_symbol: 1'b1, end_of_output: 1'b1};
    end else if (in_final_symbol) begin
      ent[n_res - 2'd1].end_of_output = 1'b1;
    end
  end

  always_comb begin
    held_nxt      = held_r;
    pos_nxt       = pos_r;
    third_pad_nxt = third_pad_r;
    invalid_nxt   = invalid_r;
    discard_nxt   = discard_r;
    push_n        = 2'd0;
    if (accept) begin
      if (discard_r) begin
        if (in_final_symbol) begin
          discard_nxt   = 1'b0;
          held_nxt      = '0;
          pos_nxt       = 2'd0;
          third_pad_nxt = 1'b0;
          invalid_nxt   = 1'b0;
        end
      end else if (!completes) begin
        held_nxt    = {held_r[11:0], sx_val};
        pos_nxt     = pos_r + 2'd1;
        invalid_nxt = invalid_r || bad_char;
        if (pos_r == 2'd2) begin
          third_pad_nxt = is_pad;
        end
      end else begin
        push_n        = n_res;
        held_nxt      = '0;
        pos_nxt       = 2'd0;
        third_pad_nxt = 1'b0;
        invalid_nxt   = 1'b0;
        discard_nxt   = grp_bad && !in_final_symbol;
      end
    end
  end

  always_comb begin
    base    = cnt_r - CntW'(pop);
    cnt_nxt = base + CntW'(push_n);
    off     = '0;
    for (int i = 0; i < b64d_pkg::QUEUE_DEPTH; i++) begin
      queue_nxt[i] = queue_r[i];
      off          = CntW'(i) - base;
      if (CntW'(i) < base) begin
        if (pop && i < b64d_pkg::QUEUE_DEPTH - 1) begin
          queue_nxt[i] = queue_r[i + 1];
        end
      end else if (off < CntW'(push_n)) begin
        queue_nxt[i] = ent[off[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r       <= 1'b0;
      held_r      <= '0;
      pos_r       <= 2'd0;
      third_pad_r <= 1'b0;
      invalid_r   <= 1'b0;
      discard_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        url_r <= cfg_url_alphabet;
      end
      held_r      <= held_nxt;
      pos_r       <= pos_nxt;
      third_pad_r <= third_pad_nxt;
      invalid_r   <= invalid_nxt;
      discard_r   <= discard_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < b64d_pkg::QUEUE_DEPTH; i++) begin
      queue_r[i] <= queue_nxt[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(b64d_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_symbol |-> out_end_of_output && out_data_byte == 8'd0)
    else $error("error result without end mark or with data");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && discard_r |=> cnt_r <= $past(cnt_r))
    else $error("result produced while discarding");

  a_group_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final_symbol |=> pos_r == 2'd0 && !invalid_r && !discard_r)
    else $error("group state not cleared after final character");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming Base64 decoder base64_decoder.
// It decodes every accepted character in its own model and checks each result.
// Depends on b64d_pkg and the decoder RTL.
module testbench;

  typedef logic [7:0] byte_q_t[$];

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;

  localparam logic [7:0] CH_UPPER_A    = "A";
  localparam logic [7:0] CH_LOWER_A    = "a";
  localparam logic [7:0] CH_DIGIT_0    = "0";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_SLASH      = "/";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_ALL_ONES   = 8'hFF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_url_alphabet = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_symbol = 8'h00;
  logic       in_final_symbol = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_bad_symbol;
  logic       out_end_of_output;

  logic        url_sel = 1'b0;
  logic [17:0] held_bits = '0;
  logic [1:0]  group_fill = '0;
  logic        third_pad = 1'b0;
  logic        group_bad = 1'b0;
  logic        dropping = 1'b0;

  b64d_pkg::result_t pending_results[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_active = 1'b0;
  event    hold_off_start;
  int      cycle_count = 0;
  int      mismatch_count = 0;
  int      chars_sent = 0;
  int      results_checked = 0;
  int      error_results = 0;

  base64_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_url_alphabet  (cfg_url_alphabet),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_symbol         (in_symbol),
    .in_final_symbol   (in_final_symbol),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_bad_symbol    (out_bad_symbol),
    .out_end_of_output (out_end_of_output)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_char(logic [5:0] v, logic url);
    if (v < 6'd26) return CH_UPPER_A + 8'(v);
    if (v < 6'd52) return CH_LOWER_A + 8'(v - 6'd26);
    if (v < 6'd62) return CH_DIGIT_0 + 8'(v - 6'd52);
    if (v == 6'd62) return url ? CH_MINUS : CH_PLUS;
    return url ? CH_UNDERSCORE : CH_SLASH;
  endfunction

  function automatic void clear_group();
    held_bits = '0;
    group_fill = '0;
    third_pad = 1'b0;
    group_bad = 1'b0;
  endfunction

  function automatic void decode_symbol(logic [7:0] sym, logic fin);
    logic              pad;
    logic              hit;
    logic [5:0]        sx;
    logic [23:0]       word;
    logic              fourth_pad;
    logic [7:0]        got[3];
    int                filled;
    int                n;
    b64d_pkg::result_t r;
    if (dropping) begin
      if (fin) begin
        dropping = 1'b0;
        clear_group();
      end
      return;
    end
    pad = (sym == b64d_pkg::PAD_CHAR);
    sx = '0;
    if (!pad) begin
      hit = 1'b0;
      for (int v = 0; v < 64; v++) begin
        if (sextet_char(6'(v), url_sel) == sym) begin
          sx = 6'(v);
          hit = 1'b1;
        end
      end
      if (!hit) group_bad = 1'b1;
    end
    if (group_fill != 2'd3) begin
      held_bits = {held_bits[11:0], sx};
      if (group_fill == 2'd2) third_pad = pad;
      filled = int'(group_fill) + 1;
      if (!fin) begin
        group_fill = 2'(filled);
        return;
      end
      while (filled < 3) begin
        held_bits = {held_bits[11:0], 6'd0};
        if (filled == 2) third_pad = 1'b1;
        filled++;
      end
      word = {held_bits, 6'd0};
      fourth_pad = 1'b1;
    end else begin
      word = {held_bits, sx};
      fourth_pad = pad;
    end
    if (group_bad) begin
      r.data_byte = 8'h00;
      r.bad_symbol = 1'b1;
      r.end_of_output = 1'b1;
      pending_results.push_back(r);
      clear_group();
      if (!fin) dropping = 1'b1;
      return;
    end
    n = 0;
    got[n] = word[23:16];
    n++;
    if (!third_pad) begin
      got[n] = word[15:8];
      n++;
    end
    if (!fourth_pad) begin
      got[n] = word[7:0];
      n++;
    end
    for (int i = 0; i < n; i++) begin
      r.data_byte = got[i];
      r.bad_symbol = 1'b0;
      r.end_of_output = fin && (i == n - 1);
      pending_results.push_back(r);
    end
    clear_group();
  endfunction

  function automatic byte_q_t encode_bytes(byte_q_t data, bit with_pad, logic url);
    byte_q_t     chars;
    logic [23:0] w;
    int          left;
    for (int i = 0; i < data.size(); i += 3) begin
      left = data.size() - i;
      w = {data[i], (left > 1) ? data[i + 1] : 8'h00, (left > 2) ? data[i + 2] : 8'h00};
      chars.push_back(sextet_char(w[23:18], url));
      chars.push_back(sextet_char(w[17:12], url));
      if (left > 1) chars.push_back(sextet_char(w[11:6], url));
      else if (with_pad) chars.push_back(b64d_pkg::PAD_CHAR);
      if (left > 2) chars.push_back(sextet_char(w[5:0], url));
      else if (with_pad) chars.push_back(b64d_pkg::PAD_CHAR);
    end
    return chars;
  endfunction

  // Most messages are well formed; the rest carry a stray pad, a random byte,
  // a character of the other alphabet, or are pure noise.
  function automatic byte_q_t random_message();
    byte_q_t data;
    byte_q_t msg;
    int      kind;
    int      idx;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(255)));
      return msg;
    end
    repeat ($urandom_range(1, 9)) data.push_back(8'($urandom_range(255)));
    msg = encode_bytes(data, bit'($urandom_range(1)), url_sel);
    idx = $urandom_range(msg.size() - 1);
    if (kind < 20) msg[idx] = b64d_pkg::PAD_CHAR;
    else if (kind < 27) msg[idx] = 8'($urandom_range(255));
    else if (kind < 32) msg[idx] = sextet_char(6'(62 + $urandom_range(1)), !url_sel);
    return msg;
  endfunction

  task automatic send_symbol(logic [7:0] sym, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_final_symbol <= fin;
    do @(posedge clk); while (!in_ready);
    decode_symbol(sym, fin);
    chars_sent++;
  endtask

  task automatic send_message(byte_q_t msg);
    foreach (msg[i]) send_symbol(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(string s, bit fin_last);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_alphabet(logic url);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_url_alphabet <= url;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    url_sel = url;
  endtask

  task automatic test_known_groups();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_text("TWFu", 1);
    send_text("TQ==", 1);
    send_text("TQ", 1);
    send_text("=A/+", 1);
    send_text("A", 0);
    send_symbol(CH_NUL, 1'b0);
    send_text("BC", 0);
    send_text("D", 1);
    send_symbol(CH_ALL_ONES, 1'b1);
  endtask

  task automatic test_url_alphabet();
    set_alphabet(1'b1);
    send_text("-_-_", 1);
    send_text("+", 1);
  endtask

  task automatic test_random_stream(logic url, int idle_pct, int stall_pct, int count);
    int start;
    set_alphabet(url);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    while (chars_sent - start < count) send_message(random_message());
  endtask

  task automatic test_receiver_hold();
    byte_q_t data;
    set_alphabet(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_off_start;
    repeat (4) begin
      data.delete();
      repeat (6) data.push_back(8'($urandom_range(255)));
      send_message(encode_bytes(data, 1'b1, url_sel));
    end
  endtask

  initial forever begin
    @(hold_off_start);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    b64d_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual data %02h bad %0b end %0b",
                   $time, out_data_byte, out_bad_symbol, out_end_of_output);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_byte !== want.data_byte) begin
            $display("%0t: data_byte: expected %02h, actual %02h",
                     $time, want.data_byte, out_data_byte);
            mismatch_count++;
          end
          if (out_bad_symbol !== want.bad_symbol) begin
            $display("%0t: bad_symbol: expected %0b, actual %0b",
                     $time, want.bad_symbol, out_bad_symbol);
            mismatch_count++;
          end
          if (out_end_of_output !== want.end_of_output) begin
            $display("%0t: end_of_output: expected %0b, actual %0b",
                     $time, want.end_of_output, out_end_of_output);
            mismatch_count++;
          end
          results_checked++;
          if (want.bad_symbol) error_results++;
        end
      end
      out_ready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("base64_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_known_groups();
    test_url_alphabet();
    test_random_stream(1'b1, 0, 0, 38);
    test_random_stream(1'b0, 63, 0, 38);
    test_random_stream(1'b1, 0, 63, 38);
    test_random_stream(1'b0, 13, 13, 38);
    test_receiver_hold();
    wait_idle();
    $display("Covered %0d characters and %0d results, %0d of them error results.",
             chars_sent, results_checked, error_results);
    $display("Both alphabets, explicit and implicit padding, bad characters and a long"
             , " output stall were exercised.");
    if (mismatch_count == 0) begin
      $display("base64_decoder regression: pass");
    end else begin
      $display("base64_decoder regression: fail");
    end
    $finish;
  end

endmodule
